FILE: design/opua_pkg.sv
// ----------------------------------------------------------------------------
// opua_pkg : shared types, constants and table functions
// Field widths, divider geometry and the sine table generator for the
// polar unwrap address pipeline.
// ----------------------------------------------------------------------------
package opua_pkg;

   // field widths
   localparam int SIDE_W   = 10;
   localparam int OFFSET_W = 16;
   localparam int COL_IN_W = 10;
   localparam int ROW_W    = 9;
   localparam int SRC_W    = 9;

   // internal widths (side is at most 1023)
   localparam int RAD_W     = 9;    // ring radius, side / 2
   localparam int COLS_W    = 12;   // floor(pi * side) <= 3213
   localparam int HALF_W    = 11;   // half of the columns
   localparam int NUM_W     = 12;   // unfolded column, out_col + half
   localparam int PHASE_W   = 16;   // turn phase
   localparam int TRIG_W    = 16;   // Q1.15 sine value
   localparam int PI_W      = 34;
   localparam int PI_FRAC_W = 32;
   localparam int PROD_W    = 26;   // radius * sine plus center, signed
   localparam int FRAC_BITS = 15;

   // column-to-phase divider: one quotient bit per step
   localparam int DIV_STEPS           = NUM_W + PHASE_W;
   localparam int DIV_STEPS_PER_STAGE = 4;
   localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

   localparam logic [PI_W-1:0]      PI_Q32       = 34'd13493037705;
   localparam longint unsigned      TWO_PI_Q30   = 64'd6746518852;
   localparam int                   Q30_SHIFT    = 30;
   localparam longint               ROUND_HALF   = 64'sd16384;
   localparam longint               Q15_MAX      = 64'sd32767;
   localparam logic [PHASE_W-1:0]   QUARTER_TURN = 16'h4000;

   localparam int SIDE_MIN          = 2;
   localparam int MAX_SIDE_DEFAULT  = 512;
   localparam int TRIG_BITS_DEFAULT = 10;

   localparam logic [SIDE_W-1:0]   SIDE_RESET   = 10'd328;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd0;

   // register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIDE_LENGTH  = 1'b0,
      CSR_ANGLE_OFFSET = 1'b1
   } csr_index_type;

   // sine series denominators (2n)(2n+1)
   localparam int TAYLOR_TERMS = 8;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

   // quarter-wave sine in Q1.15, m in 0..N/4, Taylor series in Q30
   function automatic logic signed [TRIG_W-1:0] quarter_sine(longint unsigned m,
                                                            int unsigned bits);
      longint unsigned x;
      longint unsigned t;
      longint          sum;
      longint          q;
      x   = (m * TWO_PI_Q30) >> bits;
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
         t = (t * x) >> Q30_SHIFT;
         t = (t * x) >> Q30_SHIFT;
         t = t / TAYLOR_DIV[n-1];
         if ((n & 1) != 0) begin
            sum = sum - longint'(t);
         end else begin
            sum = sum + longint'(t);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      q = (sum + ROUND_HALF) >>> FRAC_BITS;
      if (q > Q15_MAX) begin
         q = Q15_MAX;
      end
      return TRIG_W'(q);
   endfunction

   // full-wave entry k of a 2^bits table, mirrored from the quarter wave
   function automatic logic signed [TRIG_W-1:0] sine_entry(int unsigned k,
                                                          int unsigned bits);
      int unsigned             qn;
      int unsigned             quad;
      int unsigned             r;
      logic signed [TRIG_W-1:0] v;
      qn   = 1 << (bits - 2);
      quad = k >> (bits - 2);
      r    = k & (qn - 1);
      if ((quad & 1) != 0) begin
         v = quarter_sine(longint'(qn - r), bits);
      end else begin
         v = quarter_sine(longint'(r), bits);
      end
      if (quad >= 2) begin
         v = -v;
      end
      return v;
   endfunction

endpackage

FILE: design/opua_req_if.sv
// ----------------------------------------------------------------------------
// opua_req_if : request channel
// Valid/ready channel carrying one folded panorama pixel coordinate.
// ----------------------------------------------------------------------------
interface opua_req_if;
   logic                          valid;
   logic                          ready;
   logic [opua_pkg::COL_IN_W-1:0] out_col;
   logic [opua_pkg::ROW_W-1:0]    out_row;

   modport source (output valid, output out_col, output out_row, input ready);
   modport sink   (input valid, input out_col, input out_row, output ready);
endinterface

FILE: design/opua_rsp_if.sv
// ----------------------------------------------------------------------------
// opua_rsp_if : response channel
// Valid/ready channel carrying one source pixel address.
// ----------------------------------------------------------------------------
interface opua_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [opua_pkg::SRC_W-1:0] src_x;
   logic [opua_pkg::SRC_W-1:0] src_y;
   logic                       src_valid;

   modport source (output valid, output src_x, output src_y, output src_valid,
                   input ready);
   modport sink   (input valid, input src_x, input src_y, input src_valid,
                   output ready);
endinterface

FILE: design/omni_polar_unwrap_address.sv
// ----------------------------------------------------------------------------
// omni_polar_unwrap_address : folded panorama to omni image address
// Maps each folded panorama pixel to the source pixel of a square
// omni-camera image through a column-to-angle divider and a sine ROM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        contents
//  req_bus   in         valid / ready    out_col, out_row
//  rsp_bus   out        valid / ready    src_x, src_y, src_valid
//  csr_*     in         write enable     csr_index, csr_wdata
//
//  One request per cycle unless a stall on rsp_bus backs up the pipe.
//  Depth is set by the column-to-phase divider: 28 restoring steps, 4 per
//  stage, plus input, fold, ROM, multiply and output stages.
//  Every stage holds its own valid bit and advances when the next one is
//  free, so a stall on rsp_bus fills bubbles before req_bus is held off.
//  Synchronous reset empties the pipe and loads side 328, offset 0.
// ----------------------------------------------------------------------------
module omni_polar_unwrap_address #(
   parameter int MAX_SIDE        = opua_pkg::MAX_SIDE_DEFAULT,
   parameter int TRIG_TABLE_BITS = opua_pkg::TRIG_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  opua_pkg::csr_index_type         csr_index,
   input  logic [opua_pkg::CSR_DATA_W-1:0] csr_wdata,
   opua_req_if.sink                        req_bus,
   opua_rsp_if.source                      rsp_bus
);
   import opua_pkg::*;

   localparam int TRIG_N  = 1 << TRIG_TABLE_BITS;
   localparam int ADDR_W  = TRIG_TABLE_BITS;
   localparam int QUARTER = TRIG_N / 4;

   localparam int ST_IN   = 0;
   localparam int ST_FOLD = 1;
   localparam int ST_DIV  = 2;
   localparam int ST_ROM  = ST_DIV + DIV_STAGES;
   localparam int ST_MUL  = ST_ROM + 1;
   localparam int ST_OUT  = ST_MUL + 1;
   localparam int NSTG    = ST_OUT + 1;

   // ---------------- sine ROM ----------------
   logic signed [TRIG_W-1:0] sine_rom [TRIG_N];

   for (genvar k = 0; k < TRIG_N; k++) begin : g_rom
      localparam logic signed [TRIG_W-1:0] ENTRY = sine_entry(k, TRIG_TABLE_BITS);
      assign sine_rom[k] = ENTRY;
   end

   // ---------------- configuration ----------------
   logic [SIDE_W-1:0]   side_ff, side_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   always_comb begin
      side_in   = side_ff;
      offset_in = offset_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SIDE_LENGTH:  side_in   = csr_wdata[SIDE_W-1:0];
            CSR_ANGLE_OFFSET: offset_in = csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= SIDE_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         side_ff   <= side_in;
         offset_ff <= offset_in;
      end
   end

   // geometry derived from side, registered in the cycle after the side register
   logic [SIDE_W-1:0]           sclamp_ff, sclamp_in;
   logic [RAD_W-1:0]            rad_ff, rad_in;
   logic [COLS_W-1:0]           cols_ff, cols_in;
   logic [HALF_W-1:0]           half_ff, half_in;
   logic [SIDE_W+PI_W-1:0]      pi_prod;

   always_comb begin
      sclamp_in = side_ff;
      if (side_ff < SIDE_W'(SIDE_MIN)) begin
         sclamp_in = SIDE_W'(SIDE_MIN);
      end else if (int'(side_ff) > MAX_SIDE) begin
         sclamp_in = SIDE_W'(MAX_SIDE);
      end
      pi_prod = (SIDE_W+PI_W)'(sclamp_in) * (SIDE_W+PI_W)'(PI_Q32);
      cols_in = pi_prod[PI_FRAC_W +: COLS_W];
      rad_in  = sclamp_in[SIDE_W-1:1];
      half_in = cols_in[COLS_W-1:1];
   end

   always_ff @(posedge clock) begin
      sclamp_ff <= sclamp_in;
      rad_ff    <= rad_in;
      cols_ff   <= cols_in;
      half_ff   <= half_in;
   end

   // ---------------- pipeline control ----------------
   logic [NSTG-1:0] vld_ff, vld_in, adv;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || rsp_bus.ready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = req_bus.valid && !reset;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~adv) | (vld_in & adv);
      end
   end

   assign req_bus.ready = adv[ST_IN] && !reset;

   // ---------------- input stage ----------------
   logic [COL_IN_W-1:0] in_col_ff;
   logic [ROW_W-1:0]    in_row_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_IN]) begin
         in_col_ff <= req_bus.out_col;
         in_row_ff <= req_bus.out_row;
      end
   end

   // ---------------- fold stage ----------------
   logic [NUM_W-1:0] fold_col_ff, fold_col_in;
   logic [RAD_W-1:0] fold_rr_ff, fold_rr_in;
   logic             fold_ok_ff, fold_ok_in;

   always_comb begin
      fold_col_in = NUM_W'(in_col_ff);
      fold_rr_in  = in_row_ff;
      fold_ok_in  = 1'b1;
      if (in_row_ff < rad_ff) begin
         fold_ok_in = 1'b1;
      end else if ({1'b0, in_row_ff} < {rad_ff, 1'b0}) begin
         // second half of the panorama
         fold_rr_in  = in_row_ff - rad_ff;
         fold_col_in = NUM_W'(in_col_ff) + NUM_W'(half_ff);
      end else begin
         fold_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_FOLD]) begin
         fold_col_ff <= fold_col_in;
         fold_rr_ff  <= fold_rr_in;
         fold_ok_ff  <= fold_ok_in;
      end
   end

   // ---------------- column / columns divider ----------------
   // col * 2^16 / cols; only the low 16 quotient bits survive
   logic [NUM_W-1:0]   div_num_ff  [DIV_STAGES];
   logic [NUM_W-1:0]   div_num_in  [DIV_STAGES];
   logic [COLS_W-1:0]  div_rem_ff  [DIV_STAGES];
   logic [COLS_W-1:0]  div_rem_in  [DIV_STAGES];
   logic [PHASE_W-1:0] div_quot_ff [DIV_STAGES];
   logic [PHASE_W-1:0] div_quot_in [DIV_STAGES];
   logic [RAD_W-1:0]   div_rr_ff   [DIV_STAGES];
   logic [RAD_W-1:0]   div_rr_in   [DIV_STAGES];
   logic               div_ok_ff   [DIV_STAGES];
   logic               div_ok_in   [DIV_STAGES];

   always_comb begin
      logic [NUM_W-1:0]   num;
      logic [COLS_W-1:0]  rem;
      logic [PHASE_W-1:0] quot;
      logic [COLS_W:0]    trial;
      logic               qbit;
      for (int d = 0; d < DIV_STAGES; d++) begin
         if (d == 0) begin
            num  = fold_col_ff;
            rem  = '0;
            quot = '0;
            div_rr_in[d] = fold_rr_ff;
            div_ok_in[d] = fold_ok_ff;
         end else begin
            num  = div_num_ff[d-1];
            rem  = div_rem_ff[d-1];
            quot = div_quot_ff[d-1];
            div_rr_in[d] = div_rr_ff[d-1];
            div_ok_in[d] = div_ok_ff[d-1];
         end
         for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
            trial = {rem, num[NUM_W-1]};
            num   = {num[NUM_W-2:0], 1'b0};
            qbit  = (trial >= {1'b0, cols_ff});
            if (qbit) begin
               trial = trial - {1'b0, cols_ff};
            end
            rem  = trial[COLS_W-1:0];
            quot = {quot[PHASE_W-2:0], qbit};
         end
         div_num_in[d]  = num;
         div_rem_in[d]  = rem;
         div_quot_in[d] = quot;
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < DIV_STAGES; d++) begin
         if (adv[ST_DIV + d]) begin
            div_num_ff[d]  <= div_num_in[d];
            div_rem_ff[d]  <= div_rem_in[d];
            div_quot_ff[d] <= div_quot_in[d];
            div_rr_ff[d]   <= div_rr_in[d];
            div_ok_ff[d]   <= div_ok_in[d];
         end
      end
   end

   // ---------------- ROM stage ----------------
   logic [PHASE_W-1:0]       phase;
   logic [ADDR_W-1:0]        sin_addr, cos_addr;
   logic signed [TRIG_W-1:0] rom_sin_ff, rom_cos_ff;
   logic [RAD_W-1:0]         rom_rr_ff, rom_rr_in;
   logic                     rom_ok_ff, rom_ok_in;

   always_comb begin
      phase     = div_quot_ff[DIV_STAGES-1] + QUARTER_TURN + offset_ff;
      sin_addr  = phase[PHASE_W-1 -: ADDR_W];
      cos_addr  = sin_addr + ADDR_W'(QUARTER);
      rom_rr_in = div_rr_ff[DIV_STAGES-1];
      rom_ok_in = div_ok_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_ROM]) begin
         rom_sin_ff <= sine_rom[sin_addr];
         rom_cos_ff <= sine_rom[cos_addr];
         rom_rr_ff  <= rom_rr_in;
         rom_ok_ff  <= rom_ok_in;
      end
   end

   // ---------------- multiply stage ----------------
   logic signed [PROD_W-1:0] mul_x_ff, mul_x_in;
   logic signed [PROD_W-1:0] mul_y_ff, mul_y_in;
   logic                     mul_ok_ff, mul_ok_in;

   always_comb begin
      mul_x_in  = PROD_W'(signed'({1'b0, rom_rr_ff})) * PROD_W'(rom_sin_ff);
      mul_y_in  = PROD_W'(signed'({1'b0, rom_rr_ff})) * PROD_W'(rom_cos_ff);
      mul_ok_in = rom_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MUL]) begin
         mul_x_ff  <= mul_x_in;
         mul_y_ff  <= mul_y_in;
         mul_ok_ff <= mul_ok_in;
      end
   end

   // ---------------- output stage ----------------
   logic [PROD_W-1:0] sum_x, sum_y, center;
   logic [SIDE_W-1:0] pos_x, pos_y, side_max;
   logic [SRC_W-1:0]  out_x_ff, out_x_in;
   logic [SRC_W-1:0]  out_y_ff, out_y_in;
   logic              out_ok_ff, out_ok_in;

   always_comb begin
      // sums stay positive since rr < radius and |sine| < 1
      center   = PROD_W'(rad_ff) << FRAC_BITS;
      sum_x    = center + mul_x_ff;
      sum_y    = center - mul_y_ff;
      pos_x    = sum_x[FRAC_BITS +: SIDE_W];
      pos_y    = sum_y[FRAC_BITS +: SIDE_W];
      side_max = sclamp_ff - SIDE_W'(1);
      if (pos_x > side_max) begin
         pos_x = side_max;
      end
      if (pos_y > side_max) begin
         pos_y = side_max;
      end
      out_ok_in = mul_ok_ff;
      out_x_in  = mul_ok_ff ? pos_x[SRC_W-1:0] : '0;
      out_y_in  = mul_ok_ff ? pos_y[SRC_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         out_x_ff  <= out_x_in;
         out_y_ff  <= out_y_in;
         out_ok_ff <= out_ok_in;
      end
   end

   assign rsp_bus.valid     = vld_ff[ST_OUT];
   assign rsp_bus.src_x     = out_x_ff;
   assign rsp_bus.src_y     = out_y_ff;
   assign rsp_bus.src_valid = out_ok_ff;

endmodule

FILE: design/opua_checker.sv
// ----------------------------------------------------------------------------
// opua_checker : port-level checks for omni_polar_unwrap_address
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module opua_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [opua_pkg::SRC_W-1:0] src_x,
   input logic [opua_pkg::SRC_W-1:0] src_y,
   input logic                       src_valid
);

   // a held response keeps its address
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(src_x) && $stable(src_y)
                                   && $stable(src_valid))
      else $error("response changed while stalled");

   // third-fold rows read as address zero
   a_fold_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !src_valid |-> src_x == '0 && src_y == '0)
      else $error("invalid response with nonzero address");

   // a draining output never holds off requests
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request held off while response side is ready");

   // pipe is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no request taken in reset
   a_reset_ready: assert property (@(posedge clock)
      reset |-> !(req_valid && req_ready))
      else $error("request accepted during reset");

endmodule

bind omni_polar_unwrap_address opua_checker u_opua_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .src_x     (rsp_bus.src_x),
   .src_y     (rsp_bus.src_y),
   .src_valid (rsp_bus.src_valid)
);

FILE: verif/tb_omni_polar_unwrap_address.sv
// ----------------------------------------------------------------------------
// tb_omni_polar_unwrap_address : self-checking bench for the unwrap address
// Drives folded panorama coordinates under several side/offset settings and
// checks every source address against an in-bench predictor that rebuilds
// the Q1.15 sine table and the fold, phase and clamp arithmetic.
// ----------------------------------------------------------------------------
module tb_omni_polar_unwrap_address;
   timeunit 1ns;
   timeprecision 1ps;

   import opua_pkg::*;

   localparam int              LUT_BITS     = 10;
   localparam int              LUT_SIZE     = 1 << LUT_BITS;
   localparam int              LUT_QTR      = LUT_SIZE / 4;
   localparam int              SIDE_CEIL    = 512;
   localparam longint unsigned PI_SCALED    = 64'd13493037705;   // pi in Q32
   localparam longint unsigned TWO_PI_SCALED = 64'd6746518852;   // 2*pi in Q30
   localparam int              DRAIN_CYCLES = 16;
   localparam int              CYCLE_LIMIT  = 100000;

   typedef struct packed {
      logic [SRC_W-1:0] src_x;
      logic [SRC_W-1:0] src_y;
      logic             src_valid;
   } src_addr_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   opua_req_if req_bus ();
   opua_rsp_if rsp_bus ();

   omni_polar_unwrap_address dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus)
   );

   int                  sine_lut [LUT_SIZE];
   src_addr_type        addr_expect_q [$];
   logic [SIDE_W-1:0]   side_shadow   = 10'd328;
   logic [OFFSET_W-1:0] offset_shadow = 16'd0;
   bit                  quiet_mode    = 1'b0;
   int                  mismatch_count = 0;
   int                  cycle_count    = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic longint quadrant_sine(longint unsigned m);
      longint unsigned ang;
      longint unsigned term;
      longint          acc;
      longint          rounded;
      ang  = (m * TWO_PI_SCALED) >> LUT_BITS;
      term = ang;
      acc  = longint'(ang);
      for (int n = 1; n <= 8; n++) begin
         term = (term * ang) >> 30;
         term = (term * ang) >> 30;
         term = term / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = (acc + 16384) >>> 15;
      if (rounded > 32767) begin
         rounded = 32767;
      end
      return rounded;
   endfunction

   function automatic int effective_side(logic [SIDE_W-1:0] v);
      if (v < 2) begin
         return 2;
      end
      if (v > SIDE_CEIL) begin
         return SIDE_CEIL;
      end
      return int'(v);
   endfunction

   function automatic int panorama_cols(int s);
      return int'((longint'(s) * PI_SCALED) >> 32);
   endfunction

   function automatic src_addr_type predict_src_addr(logic [COL_IN_W-1:0] col_in,
                                                     logic [ROW_W-1:0]    row_in);
      longint       s;
      longint       radius;
      longint       ncols;
      longint       fold;
      longint       ring;
      longint       ucol;
      longint       phase;
      longint       idx;
      longint       sn;
      longint       cs;
      longint       sx;
      longint       sy;
      src_addr_type a;
      s      = effective_side(side_shadow);
      radius = s / 2;
      ncols  = panorama_cols(int'(s));
      fold   = longint'(row_in) / radius;
      ring   = longint'(row_in) % radius;
      a      = '0;
      // third fold reads as a blank pixel
      if (fold >= 2) begin
         return a;
      end
      ucol  = longint'(col_in) + (ncols / 2) * fold;
      phase = ((ucol * 65536) / ncols + 16384 + longint'(offset_shadow)) & 64'hFFFF;
      idx   = phase >> (16 - LUT_BITS);
      sn    = sine_lut[idx];
      cs    = sine_lut[(idx + LUT_QTR) % LUT_SIZE];
      sx    = (radius * 32768 + ring * sn) >>> 15;
      sy    = (radius * 32768 - ring * cs) >>> 15;
      if (sx > s - 1) begin
         sx = s - 1;
      end
      if (sy > s - 1) begin
         sy = s - 1;
      end
      a.src_x     = sx[SRC_W-1:0];
      a.src_y     = sy[SRC_W-1:0];
      a.src_valid = 1'b1;
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx == CSR_SIDE_LENGTH) begin
         side_shadow = data[SIDE_W-1:0];
      end else begin
         offset_shadow = data[OFFSET_W-1:0];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_pixel(logic [COL_IN_W-1:0] col, logic [ROW_W-1:0] row);
      while (!quiet_mode && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.out_col <= col;
      req_bus.out_row <= row;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      addr_expect_q.push_back(predict_src_addr(col, row));
      @(negedge clock);
   endtask

   // hold off requests until every outstanding address is back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (addr_expect_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= quiet_mode || ($urandom_range(99) >= 6);
      end
   end

   always @(posedge clock) begin : addr_check
      src_addr_type got;
      src_addr_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.src_x     = rsp_bus.src_x;
         got.src_y     = rsp_bus.src_y;
         got.src_valid = rsp_bus.src_valid;
         if (addr_expect_q.size() == 0) begin
            $display("%0t: unexpected address x=%0d y=%0d v=%0d", $time,
                     got.src_x, got.src_y, got.src_valid);
            mismatch_count++;
         end else begin
            want = addr_expect_q.pop_front();
            if (got !== want) begin
               $display("%0t: expected x=%0d y=%0d v=%0d, actual x=%0d y=%0d v=%0d",
                        $time, want.src_x, want.src_y, want.src_valid,
                        got.src_x, got.src_y, got.src_valid);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("omni_polar_unwrap_address: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset setting: side 328, radius 164, 1030 columns, 515 per half
   task automatic test_default_geometry();
      send_pixel(10'd0, 9'd0);
      send_pixel(10'd514, 9'd0);
      send_pixel(10'd514, 9'd163);
      send_pixel(10'd0, 9'd164);
      send_pixel(10'd514, 9'd327);
      send_pixel(10'd1023, 9'd327);   // column past the half, phase wraps
      send_pixel(10'd0, 9'd328);      // row past the image lands in fold 2
      send_pixel(10'd1023, 9'd511);
      wait_for_drain();
   endtask

   task automatic test_side_extremes();
      write_csr(CSR_SIDE_LENGTH, 16'd2);
      write_csr(CSR_ANGLE_OFFSET, 16'hFFFF);
      send_pixel(10'd0, 9'd0);
      send_pixel(10'd2, 9'd1);
      send_pixel(10'd0, 9'd2);
      send_pixel(10'd1023, 9'd1);
      wait_for_drain();
      write_csr(CSR_SIDE_LENGTH, 16'd512);
      write_csr(CSR_ANGLE_OFFSET, 16'h0000);
      send_pixel(10'd0, 9'd511);
      send_pixel(10'd803, 9'd511);
      send_pixel(10'd803, 9'd255);
      send_pixel(10'd0, 9'd256);
      wait_for_drain();
      // upper data bits are dropped; side 1 clamps up to 2
      write_csr(CSR_SIDE_LENGTH, 16'hFC01);
      send_pixel(10'd1, 9'd1);
      wait_for_drain();
      // side 1023 clamps down to the maximum
      write_csr(CSR_SIDE_LENGTH, 16'h03FF);
      write_csr(CSR_ANGLE_OFFSET, 16'h8000);
      send_pixel(10'd400, 9'd300);
      wait_for_drain();
      // odd side: last row is a third fold
      write_csr(CSR_SIDE_LENGTH, 16'd5);
      send_pixel(10'd7, 9'd4);
      send_pixel(10'd3, 9'd3);
      wait_for_drain();
   endtask

   task automatic run_random_phase(int n_items);
      int                    pick;
      int                    s;
      int                    half;
      logic [SIDE_W-1:0]     side_val;
      logic [OFFSET_W-1:0]   offset_val;
      pick = $urandom_range(99);
      if (pick < 8) begin
         side_val = SIDE_W'($urandom_range(1));
      end else if (pick < 16) begin
         side_val = SIDE_W'($urandom_range(1023, 513));
      end else if (pick < 30) begin
         side_val = ($urandom_range(1) != 0) ? 10'd2 : 10'd512;
      end else if (pick < 45) begin
         side_val = SIDE_W'($urandom_range(40) * 2 + 3);
      end else begin
         side_val = SIDE_W'($urandom_range(512, 2));
      end
      pick = $urandom_range(9);
      if (pick == 0) begin
         offset_val = 16'h0000;
      end else if (pick == 1) begin
         offset_val = 16'hFFFF;
      end else begin
         offset_val = OFFSET_W'($urandom_range(65535));
      end
      write_csr(CSR_SIDE_LENGTH, {6'($urandom_range(63)), side_val});
      write_csr(CSR_ANGLE_OFFSET, offset_val);
      s    = effective_side(side_shadow);
      half = panorama_cols(s) / 2;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 85) begin
            send_pixel(COL_IN_W'($urandom_range(half - 1)), ROW_W'($urandom_range(s - 1)));
         end else begin
            send_pixel(COL_IN_W'($urandom_range(1023)), ROW_W'($urandom_range(511)));
         end
      end
      wait_for_drain();
   endtask

   task automatic test_random_fold_sweep(int n_phases, int per_phase);
      for (int p = 0; p < n_phases; p++) begin
         run_random_phase(per_phase);
      end
   endtask

   // full rate on both sides, no idle cycles anywhere
   task automatic test_back_to_back(int n_items);
      quiet_mode = 1'b1;
      run_random_phase(n_items);
      quiet_mode = 1'b0;
   endtask

   initial begin
      int     quad;
      int     rem;
      longint mag;
      for (int k = 0; k < LUT_SIZE; k++) begin
         quad = k / LUT_QTR;
         rem  = k % LUT_QTR;
         mag  = (quad % 2 == 1) ? quadrant_sine(LUT_QTR - rem) : quadrant_sine(rem);
         sine_lut[k] = (quad >= 2) ? -int'(mag) : int'(mag);
      end
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = CSR_SIDE_LENGTH;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.out_col = '0;
      req_bus.out_row = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_geometry();
      test_side_extremes();
      test_random_fold_sweep(6, 105);
      test_back_to_back(100);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("omni_polar_unwrap_address: match");
      end else begin
         $display("omni_polar_unwrap_address: mismatch");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/opua_pkg.sv
design/opua_req_if.sv
design/opua_rsp_if.sv
design/omni_polar_unwrap_address.sv
design/opua_checker.sv
verif/tb_omni_polar_unwrap_address.sv
